// ----- hdl/lfo_waveform_generator_top_macros.svh -----
`ifndef LFO_WAVEFORM_GENERATOR_TOP_MACROS_SVH
`define LFO_WAVEFORM_GENERATOR_TOP_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define LFO_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lfo check failed in the same cycle");

// Check a consequent in the cycle after its antecedent.
`define LFO_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lfo check failed in the following cycle");

`endif

// ----- hdl/lfo_pkg.sv -----
package lfo_pkg;

    localparam int SINE_TABLE_BITS_DEF = 8;
    localparam int WAVE_FRAC_BITS_DEF  = 15;

    localparam int Q215_MAX = 131071;
    localparam int Q215_MIN = -131072;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_TRIANGLE = 2'd1,
        WAVE_SQUARE   = 2'd2,
        WAVE_SAWTOOTH = 2'd3
    } wave_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ENABLE          = 3'd0,
        CFG_WAVE_TYPE       = 3'd1,
        CFG_PHASE_INCREMENT = 3'd2,
        CFG_START_PHASE     = 3'd3,
        CFG_AMPLITUDE       = 3'd4,
        CFG_LEVEL_OFFSET    = 3'd5
    } cfg_reg_t;

    // Quarter-wave sine entry k, evaluated at elaboration: Q30 Taylor sum of
    // sin(pi/2 * k / 2^table_bits), each product truncated, rounded to frac_bits.
    function automatic logic [63:0] sine_entry(input int unsigned k,
                                               input int unsigned table_bits,
                                               input int unsigned frac_bits);
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        one;
        logic [63:0]        v;
        x    = (64'd1686629713 * 64'(k)) >> table_bits;
        term = x;
        sum  = signed'(x);
        for (int n = 1; n < 10; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            case (n)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                5:       term = term / 64'd110;
                6:       term = term / 64'd156;
                7:       term = term / 64'd210;
                8:       term = term / 64'd272;
                default: term = term / 64'd342;
            endcase
            if ((n & 1) != 0) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0) begin
            sum = 64'sd0;
        end
        one = 64'd1 << frac_bits;
        v   = (unsigned'(sum) * one + (64'd1 << 29)) >> 30;
        if (v > one) begin
            v = one;
        end
        return v;
    endfunction

endpackage

// ----- hdl/lfo_wave_shaper.sv -----
module lfo_wave_shaper
    import lfo_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
    parameter int WAVE_FRAC_BITS  = WAVE_FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            load_i,
    input  logic [31:0]                     phase_i,
    input  wave_t                           wave_type_i,
    output logic signed [WAVE_FRAC_BITS+1:0] wave_o
);

    localparam int WW      = WAVE_FRAC_BITS + 2;
    localparam int AW      = SINE_TABLE_BITS + 1;
    localparam int QTR_LEN = 1 << SINE_TABLE_BITS;

    localparam logic signed [WW-1:0] WAVE_ONE   = WW'(QTR_LEN - QTR_LEN + (1 << WAVE_FRAC_BITS));
    localparam logic signed [WW:0]   WAVE_ONE_X = (WW+1)'(1 << WAVE_FRAC_BITS);
    localparam logic signed [WW:0]   WAVE_3_X   = (WW+1)'(3 << WAVE_FRAC_BITS);

    typedef logic [WAVE_FRAC_BITS:0] rom_word_t;
    typedef rom_word_t rom_t [QTR_LEN+1];

    function automatic rom_t build_rom();
        rom_t rom;
        for (int k = 0; k <= QTR_LEN; k++) begin
            rom[k] = rom_word_t'(sine_entry(k, SINE_TABLE_BITS, WAVE_FRAC_BITS));
        end
        return rom;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic [SINE_TABLE_BITS-1:0] idx;
    logic [AW-1:0]              rom_addr;
    logic signed [WW:0]         tri_u;
    logic signed [WW:0]         tri_wide;
    logic signed [WW-1:0]       saw_val;
    logic signed [WW-1:0]       other_next;

    rom_word_t                  rom_q_reg;
    logic                       is_sine_reg;
    logic                       negate_reg;
    logic signed [WW-1:0]       other_reg;
    logic signed [WW-1:0]       sine_val;

    always_comb begin
        idx = phase_i[29 -: SINE_TABLE_BITS];
        // Odd quadrants read the table mirrored.
        if (phase_i[30]) begin
            rom_addr = AW'(QTR_LEN) - {1'b0, idx};
        end else begin
            rom_addr = {1'b0, idx};
        end

        tri_u = signed'({1'b0, phase_i[31:30-WAVE_FRAC_BITS]});
        if (!phase_i[31]) begin
            tri_wide = tri_u - WAVE_ONE_X;
        end else begin
            tri_wide = WAVE_3_X - tri_u;
        end

        saw_val = signed'({1'b0, phase_i[31:31-WAVE_FRAC_BITS]}) - WAVE_ONE;

        case (wave_type_i)
            WAVE_TRIANGLE: other_next = tri_wide[WW-1:0];
            WAVE_SQUARE:   other_next = phase_i[31] ? -WAVE_ONE : WAVE_ONE;
            WAVE_SAWTOOTH: other_next = saw_val;
            default:       other_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (load_i) begin
            rom_q_reg   <= SINE_ROM[rom_addr];
            is_sine_reg <= (wave_type_i == WAVE_SINE);
            negate_reg  <= phase_i[31];
            other_reg   <= other_next;
        end
    end

    always_comb begin
        sine_val = signed'({1'b0, rom_q_reg});
        if (is_sine_reg) begin
            wave_o = negate_reg ? -sine_val : sine_val;
        end else begin
            wave_o = other_reg;
        end
    end

endmodule

// ----- hdl/lfo_waveform_generator_top.sv -----
// Throughput: one item per cycle while m_tready stays high; the four register stages (phase, table read,
// product, saturated result) each hold one item and move on whenever the next is free.
// Reset: synchronous, active low; clears stage valids, the phase accumulator and
// the configuration registers (amplitude to 1.0, everything else to zero).
module lfo_waveform_generator_top
    import lfo_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
    parameter int WAVE_FRAC_BITS  = WAVE_FRAC_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [0] restart, [7:1] zero

    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [23:0]            m_tdata    // [17:0] lfo_value, [18] clipped, [23:19] zero
);

    `include "lfo_waveform_generator_top_macros.svh"

    localparam int WW     = WAVE_FRAC_BITS + 2;
    localparam int PW     = WW + 18;
    localparam int RW     = PW + 1;
    localparam int SW     = RW - WAVE_FRAC_BITS;
    localparam int SUM_W  = SW + 1;

    localparam logic signed [RW-1:0]    ROUND_HALF = RW'(1 << (WAVE_FRAC_BITS - 1));
    localparam logic signed [SUM_W-1:0] SUM_MAX    = SUM_W'(Q215_MAX);
    localparam logic signed [SUM_W-1:0] SUM_MIN    = SUM_W'(Q215_MIN);

    // Configuration registers
    logic               enable_reg;
    wave_t              wave_type_reg;
    logic [31:0]        phase_inc_reg;
    logic [31:0]        start_phase_reg;
    logic signed [17:0] amplitude_reg;
    logic signed [17:0] level_offset_reg;

    // Pipeline control
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;
    logic ld1, ld2, ld3, ld4;

    // Datapath
    logic [31:0]          acc_reg;
    logic [31:0]          phase_sel;
    logic [31:0]          phase1_reg;
    logic signed [WW-1:0] wave;
    logic signed [PW-1:0] prod_reg;
    logic signed [RW-1:0] rounded;
    logic signed [RW-1:0] shifted;
    logic signed [SUM_W-1:0] sum;
    logic signed [17:0]   value_next;
    logic                 clip_next;
    logic signed [17:0]   value_reg;
    logic                 clip_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg       <= 1'b0;
            wave_type_reg    <= WAVE_SINE;
            phase_inc_reg    <= '0;
            start_phase_reg  <= '0;
            amplitude_reg    <= 18'sd32768;
            level_offset_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                CFG_ENABLE:          enable_reg       <= cfg_data[0];
                CFG_WAVE_TYPE:       wave_type_reg    <= wave_t'(cfg_data[1:0]);
                CFG_PHASE_INCREMENT: phase_inc_reg    <= cfg_data;
                CFG_START_PHASE:     start_phase_reg  <= cfg_data;
                CFG_AMPLITUDE:       amplitude_reg    <= signed'(cfg_data[17:0]);
                CFG_LEVEL_OFFSET:    level_offset_reg <= signed'(cfg_data[17:0]);
                default: ;
            endcase
        end
    end

    // A stage takes a new item when it is empty or its item moves on
    assign rdy4 = !v4_reg || m_tready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign ld1 = s_tvalid && rdy1;
    assign ld2 = v1_reg && rdy2;
    assign ld3 = v2_reg && rdy3;
    assign ld4 = v3_reg && rdy4;

    assign s_tready = rdy1;
    assign m_tvalid = v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            acc_reg <= '0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (ld1) begin
                acc_reg <= phase_sel + phase_inc_reg;
            end
        end
    end

    assign phase_sel = s_tdata[0] ? start_phase_reg : acc_reg;

    always_ff @(posedge aclk) begin
        if (ld1) begin
            phase1_reg <= phase_sel;
        end
    end

    lfo_wave_shaper #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .WAVE_FRAC_BITS  (WAVE_FRAC_BITS)
    ) u_shaper (
        .aclk        (aclk),
        .load_i      (ld2),
        .phase_i     (phase1_reg),
        .wave_type_i (wave_type_reg),
        .wave_o      (wave)
    );

    always_ff @(posedge aclk) begin
        if (ld3) begin
            prod_reg <= PW'(wave) * PW'(amplitude_reg);
        end
    end

    // Round half up to Q.15 (floor after adding a half), add offset, saturate; zero while disabled
    always_comb begin
        rounded = RW'(prod_reg) + ROUND_HALF;
        shifted = rounded >>> WAVE_FRAC_BITS;
        sum     = SUM_W'(signed'(shifted[SW-1:0])) + SUM_W'(level_offset_reg);
        if (!enable_reg) begin
            value_next = '0;
            clip_next  = 1'b0;
        end else if (sum > SUM_MAX) begin
            value_next = SUM_MAX[17:0];
            clip_next  = 1'b1;
        end else if (sum < SUM_MIN) begin
            value_next = SUM_MIN[17:0];
            clip_next  = 1'b1;
        end else begin
            value_next = sum[17:0];
            clip_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld4) begin
            value_reg <= value_next;
            clip_reg  <= clip_next;
        end
    end

    assign m_tdata = {5'b0, clip_reg, value_reg};

    `LFO_ASSERT_SAME(a_clip_at_rail, v4_reg && clip_reg,
        value_reg == SUM_MAX[17:0] || value_reg == SUM_MIN[17:0])
    `LFO_ASSERT_SAME(a_disabled_zero, v4_reg && !enable_reg,
        value_reg == 18'sd0 && !clip_reg)
    `LFO_ASSERT_NEXT(a_acc_advance, ld1 && !s_tdata[0],
        acc_reg == $past(acc_reg) + $past(phase_inc_reg))
    `LFO_ASSERT_NEXT(a_restart_load, ld1 && s_tdata[0],
        phase1_reg == $past(start_phase_reg))

endmodule

// ----- tb/sv/lfo_waveform_generator_top_tb.sv -----
module lfo_waveform_generator_top_tb;
    import lfo_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     TBL_BITS    = SINE_TABLE_BITS_DEF;
    localparam int     WAVE_FRAC   = WAVE_FRAC_BITS_DEF;
    localparam int     QTR_LEN     = 1 << TBL_BITS;
    localparam longint WAVE_ONE    = longint'(1) << WAVE_FRAC;
    localparam int     STALL_LIMIT = 5000;
    localparam int     PHASE_ITEMS = 525;

    // Indexes past the register list; writes there must change nothing.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [17:0] value;
        logic        clipped;
    } lfo_sample_t;

    typedef struct packed {
        bit          set_regs;
        bit          en;
        wave_t       wave;
        logic [31:0] inc;
        logic [31:0] start;
        int          amp;
        int          off;
        bit          restart;
        bit          typed;
        int          value;
        bit          clip;
    } tone_row_t;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [23:0]            m_tdata;

    // Register and phase copy of the oscillator.
    bit                 gen_enable      = 1'b0;
    wave_t              gen_wave        = WAVE_SINE;
    logic [31:0]        gen_step        = '0;
    logic [31:0]        gen_start_phase = '0;
    logic signed [17:0] gen_gain        = 18'sd32768;
    logic signed [17:0] gen_offset      = '0;
    logic [31:0]        gen_phase       = '0;
    longint             qsine [0:QTR_LEN];

    lfo_sample_t lfo_samples_due [$];

    int sample_errors   = 0;
    int samples_checked = 0;
    int items_sent      = 0;
    int clip_hits       = 0;
    int retunes         = 0;
    int wave_hits [4]   = '{0, 0, 0, 0};
    int src_idle_pct    = 32;
    int sink_idle_pct   = 88;
    bit steady_burst    = 1'b0;

    tone_row_t tone_rows [25] = '{
        '{0, 0, WAVE_SINE,     0,            0,            0,       0,       0, 1, 0,       0},
        '{1, 1, WAVE_SQUARE,   0,            0,            32768,   0,       1, 1, 32768,   0},
        '{1, 1, WAVE_SQUARE,   0,            32'h8000_0000, 32768,  0,       1, 1, -32768,  0},
        '{1, 1, WAVE_SQUARE,   0,            0,            131071,  131071,  1, 1, 131071,  1},
        '{1, 1, WAVE_SQUARE,   0,            32'h8000_0000, 131071, -131072, 1, 1, -131072, 1},
        '{1, 1, WAVE_SQUARE,   0,            0,            -131072, 0,       1, 1, -131072, 0},
        '{1, 1, WAVE_SQUARE,   0,            32'h8000_0000, -131072, 0,      1, 1, 131071,  1},
        '{1, 1, WAVE_SQUARE,   0,            0,            0,       131071,  1, 1, 131071,  0},
        '{1, 1, WAVE_SAWTOOTH, 0,            0,            32768,   0,       1, 1, -32768,  0},
        '{1, 1, WAVE_SAWTOOTH, 0,            32'hFFFF_FFFF, 32768,  0,       1, 1, 32767,   0},
        '{1, 1, WAVE_TRIANGLE, 0,            0,            32768,   0,       1, 1, -32768,  0},
        '{1, 1, WAVE_TRIANGLE, 0,            32'h4000_0000, 32768,  0,       1, 1, 0,       0},
        '{1, 1, WAVE_TRIANGLE, 0,            32'h8000_0000, 32768,  0,       1, 1, 32768,   0},
        '{1, 1, WAVE_TRIANGLE, 0,            32'hFFFF_FFFF, 32768,  0,       1, 1, -32767,  0},
        '{1, 1, WAVE_SINE,     0,            0,            32768,   0,       1, 1, 0,       0},
        '{1, 1, WAVE_SINE,     32'h0100_0000, 32'h4000_0000, 32768, 0,       1, 0, 0,       0},
        '{0, 0, WAVE_SINE,     0,            0,            0,       0,       0, 0, 0,       0},
        '{0, 0, WAVE_SINE,     0,            0,            0,       0,       0, 0, 0,       0},
        '{1, 1, WAVE_SINE,     32'h4000_0000, 32'hC000_0000, -131072, 5,     1, 0, 0,       0},
        '{0, 0, WAVE_SINE,     0,            0,            0,       0,       0, 0, 0,       0},
        '{0, 0, WAVE_SINE,     0,            0,            0,       0,       0, 0, 0,       0},
        '{1, 0, WAVE_SQUARE,   32'hFFFF_FFFF, 0,           131071,  131071,  1, 1, 0,       0},
        '{1, 1, WAVE_SAWTOOTH, 32'hFFFF_FFFF, 32'h0000_0001, -1,    -1,      0, 0, 0,       0},
        '{0, 0, WAVE_SINE,     0,            0,            0,       0,       0, 0, 0,       0},
        '{1, 1, WAVE_TRIANGLE, 32'h1234_5679, 32'h7FFF_FFFF, 3,     -5,      1, 0, 0,       0}
    };

    lfo_waveform_generator_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Quarter-wave table: truncated Q30 Taylor series of sin, rounded to the wave scale.
    initial begin : quarter_sine
        longint unsigned x;
        longint unsigned term;
        longint          sum;
        longint          v;
        for (int k = 0; k <= QTR_LEN; k++) begin
            x    = (64'd1686629713 * longint'(k)) >> TBL_BITS;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n < 10; n++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / longint'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            v = (sum * WAVE_ONE + (longint'(1) << 29)) >>> 30;
            qsine[k] = (v > WAVE_ONE) ? WAVE_ONE : v;
        end
    end

    function automatic longint wave_at(logic [31:0] ph);
        logic [1:0] quad;
        int         idx;
        longint     s;
        longint     u;
        quad = ph[31:30];
        idx  = int'((ph >> (30 - TBL_BITS)) & (QTR_LEN - 1));
        case (gen_wave)
            WAVE_SINE: begin
                s = quad[0] ? qsine[QTR_LEN - idx] : qsine[idx];
                return quad[1] ? -s : s;
            end
            WAVE_TRIANGLE: begin
                u = ph >> (30 - WAVE_FRAC);
                return ph[31] ? 3 * WAVE_ONE - u : u - WAVE_ONE;
            end
            WAVE_SQUARE: begin
                return ph[31] ? -WAVE_ONE : WAVE_ONE;
            end
            default: begin
                u = ph >> (31 - WAVE_FRAC);
                return u - WAVE_ONE;
            end
        endcase
    endfunction

    // One sample tick: optional reload, scale, offset, saturate (zero when disabled), then advance the phase.
    function automatic lfo_sample_t next_lfo_sample(bit restart);
        lfo_sample_t r;
        longint      v;
        r = '0;
        if (restart) begin
            gen_phase = gen_start_phase;
        end
        if (gen_enable) begin
            v = ((wave_at(gen_phase) * longint'(gen_gain) + WAVE_ONE / 2) >>> WAVE_FRAC)
                + longint'(gen_offset);
            if (v > Q215_MAX) begin
                v         = Q215_MAX;
                r.clipped = 1'b1;
            end else if (v < Q215_MIN) begin
                v         = Q215_MIN;
                r.clipped = 1'b1;
            end
            r.value = v[17:0];
        end
        gen_phase = gen_phase + gen_step;
        return r;
    endfunction

    task automatic flag_sample_error(string what);
        sample_errors++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_ENABLE:          gen_enable      = data[0];
            CFG_WAVE_TYPE:       gen_wave        = wave_t'(data[1:0]);
            CFG_PHASE_INCREMENT: gen_step        = data;
            CFG_START_PHASE:     gen_start_phase = data;
            CFG_AMPLITUDE:       gen_gain        = signed'(data[17:0]);
            CFG_LEVEL_OFFSET:    gen_offset      = signed'(data[17:0]);
            default: ;
        endcase
    endtask

    // Drop the input valid and hold until every sample in flight has come out.
    task automatic settle_pipeline();
        s_tvalid <= 1'b0;
        while (lfo_samples_due.size() != 0) @(posedge aclk);
    endtask

    task automatic send_item(bit restart, bit typed, lfo_sample_t typed_val);
        lfo_sample_t want;
        while (!steady_burst && $urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, restart};
        do @(posedge aclk); while (!s_tready);
        if (gen_enable) begin
            wave_hits[gen_wave]++;
        end
        want = next_lfo_sample(restart);
        if (typed) begin
            want = typed_val;
        end
        lfo_samples_due = {lfo_samples_due, want};
        items_sent++;
    endtask

    function automatic logic [17:0] pick_q215();
        int t;
        case ($urandom_range(6))
            0: return 18'h20000;
            1: return 18'h1FFFF;
            2: return 18'h00000;
            3: return 18'h08000;
            4: return 18'h38000;
            5: begin
                t = $urandom_range(2000);
                return 18'(t - 1000);
            end
            default: return 18'($urandom);
        endcase
    endfunction

    task automatic retune_random();
        logic [31:0] junk;
        logic [31:0] v;
        settle_pipeline();
        retunes++;
        steady_burst = ($urandom_range(4) == 0);
        junk = $urandom;
        if ($urandom_range(9) < 6) begin
            write_reg(CFG_ENABLE, {junk[31:1], 1'($urandom_range(99) < 85)});
        end
        if ($urandom_range(9) < 6) begin
            write_reg(CFG_WAVE_TYPE, {junk[31:2], 2'($urandom_range(3))});
        end
        if ($urandom_range(9) < 6) begin
            case ($urandom_range(5))
                0: v = '0;
                1: v = '1;
                2: v = 32'h8000_0000;
                3: v = $urandom;
                4: v = $urandom_range(32'h00FF_FFFF);
                default: v = $urandom_range(32'h0FFF_FFFF);
            endcase
            write_reg(CFG_PHASE_INCREMENT, v);
        end
        if ($urandom_range(9) < 6) begin
            case ($urandom_range(3))
                0: v = '0;
                1: v = '1;
                2: v = {2'($urandom_range(3)), 30'b0};
                default: v = $urandom;
            endcase
            write_reg(CFG_START_PHASE, v);
        end
        if ($urandom_range(9) < 6) begin
            write_reg(CFG_AMPLITUDE, {junk[31:18], pick_q215()});
        end
        if ($urandom_range(9) < 6) begin
            write_reg(CFG_LEVEL_OFFSET, {junk[31:18], pick_q215()});
        end
        if ($urandom_range(9) == 0) begin
            write_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, $urandom);
        end
        cfg_valid <= 1'b0;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady_burst || ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge aclk) begin : sample_check
        lfo_sample_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (lfo_samples_due.size() == 0) begin
                flag_sample_error($sformatf("sample %h with none due", m_tdata));
            end else begin
                want = lfo_samples_due.pop_front();
                if (m_tdata[17:0] !== want.value) begin
                    flag_sample_error($sformatf("lfo_value got %0d, want %0d",
                        signed'(m_tdata[17:0]), signed'(want.value)));
                end
                if (m_tdata[18] !== want.clipped) begin
                    flag_sample_error($sformatf("clipped got %b, want %b",
                        m_tdata[18], want.clipped));
                end
                if (m_tdata[18] === 1'b1) begin
                    clip_hits++;
                end
                samples_checked++;
            end
        end
    end

    initial begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                    || (cfg_valid && cfg_ready)) begin
                stalled = 0;
            end else begin
                stalled++;
            end
        end
        $display("lfo_waveform_generator_top regression: fail");
        $finish;
    end

    initial begin : stimulus
        tone_row_t   row;
        lfo_sample_t typed_val;
        int          run_len;
        int          phase_items;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (tone_rows[i]) begin
            row = tone_rows[i];
            if (row.set_regs) begin
                settle_pipeline();
                write_reg(CFG_ENABLE, 32'(row.en));
                write_reg(CFG_WAVE_TYPE, 32'(row.wave));
                write_reg(CFG_PHASE_INCREMENT, row.inc);
                write_reg(CFG_START_PHASE, row.start);
                write_reg(CFG_AMPLITUDE, 32'(row.amp));
                write_reg(CFG_LEVEL_OFFSET, 32'(row.off));
                cfg_valid <= 1'b0;
                retunes++;
            end
            typed_val.value   = 18'(row.value);
            typed_val.clipped = row.clip;
            send_item(row.restart, row.typed, typed_val);
        end

        // Receiver-heavy idling, then sender-heavy, then none at all.
        for (int p = 0; p < 3; p++) begin
            src_idle_pct  = (p == 0) ? 32 : (p == 1) ? 88 : 0;
            sink_idle_pct = (p == 0) ? 88 : (p == 1) ? 32 : 0;
            phase_items   = 0;
            while (phase_items < PHASE_ITEMS) begin
                retune_random();
                run_len = $urandom_range(8, 60);
                repeat (run_len) begin
                    send_item($urandom_range(15) == 0, 1'b0, '0);
                end
                phase_items += run_len;
            end
        end

        steady_burst = 1'b0;
        settle_pipeline();
        repeat (8) @(posedge aclk);

        $display("run covered %0d samples (%0d checked) across %0d register settings, %0d saturated",
                 items_sent, samples_checked, retunes, clip_hits);
        $display("enabled samples per wave sine/triangle/square/sawtooth: %0d/%0d/%0d/%0d",
                 wave_hits[0], wave_hits[1], wave_hits[2], wave_hits[3]);
        if (sample_errors == 0 && lfo_samples_due.size() == 0) begin
            $display("lfo_waveform_generator_top regression: pass");
        end else begin
            $display("lfo_waveform_generator_top regression: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/lfo_pkg.sv
hdl/lfo_wave_shaper.sv
hdl/lfo_waveform_generator_top.sv
tb/sv/lfo_waveform_generator_top_tb.sv
